// ===== src/string_key_hash_table_unit_defines.svh =====
// ---------------------------------------------------------------------------
// String key hash table: assertion macros
// Shared immediate-implication and next-cycle-implication property forms.
// ---------------------------------------------------------------------------
`ifndef STRING_KEY_HASH_TABLE_UNIT_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SKHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SKHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/skht_pkg.sv =====
// ---------------------------------------------------------------------------
// String key hash table package
// Command and status codes, hash constants and the sequencer state type.
// ---------------------------------------------------------------------------
package skht_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOCATE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNDEF  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  // djb2 hash
  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int          HASH_SHIFT = 5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_HOME,
    ST_HOME_CHK,
    ST_SCAN,
    ST_RD,
    ST_RD_CHK,
    ST_DONE
  } state_t;

endpackage

// ===== src/string_key_hash_table_unit.sv =====
// ---------------------------------------------------------------------------
// String key hash table unit
// Open-addressed table of string keys and values, djb2 home slot, linear
// fallback scan from slot 0, under a small sequencer.
// ---------------------------------------------------------------------------
// Usage: after reset the unit sweeps its valid-bit memory and holds in_stall
// high meanwhile. Afterwards it takes one command beat at a time and stalls
// the input until that command is finished. A read passes from accept through
// the slot read and its check to the result. An insert or a locate hashes the
// key bytes (one shared 64-bit multiply-by-33 adder), runs a bit-serial
// modulo reduction when CAPACITY is not a power of two, probes the home slot
// and, when the home probe misses, scans the slot memory from slot 0 at one
// read port entry per cycle, then posts the result. An insert into a full
// table goes straight to the result. The scan through the slot memory is the
// longest step at the default CAPACITY of 64.
// A result sits in an output register, so the next command beat is taken
// while the previous result still waits behind out_stall.
module string_key_hash_table_unit #(
  parameter int CAPACITY      = 64,
  parameter int VALUE_BITS    = 32,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // command beat
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_key_bytes,
  input  logic [3:0]  in_key_len,
  input  logic [31:0] in_value_in,
  input  logic [5:0]  in_slot_index,
  // result beat
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_index_out,
  output logic [31:0] out_value_out,
  output logic [1:0]  out_status
);
  import skht_pkg::*;

  localparam int AW = $clog2(CAPACITY);       // slot address
  localparam int CW = $clog2(CAPACITY + 1);   // counts up to CAPACITY
  localparam int RW = AW + 1;                 // modulo remainder before subtract
  localparam int KW = 8 * MAX_KEY_BYTES;      // stored key bits
  localparam int DW = 4 + KW + VALUE_BITS;    // slot entry: length, key, value
  localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

  // -------------------------------------------------------------------------
  // Slot memories. Valid bits are swept clear after reset; key, length and
  // value are only meaningful once written.
  // -------------------------------------------------------------------------
  logic          valid_mem [CAPACITY];
  logic [DW-1:0] data_mem  [CAPACITY];

  logic [AW-1:0] rd_addr;
  logic          rd_valid_q;
  logic [DW-1:0] rd_data_q;
  logic [AW-1:0] wr_addr;
  logic          vwr_en;
  logic          vwr_data;
  logic          dwr_en;
  logic [DW-1:0] dwr_data;

  always_ff @(posedge clk) begin
    rd_valid_q <= valid_mem[rd_addr];
    if (vwr_en) begin
      valid_mem[wr_addr] <= vwr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_q <= data_mem[rd_addr];
    if (dwr_en) begin
      data_mem[wr_addr] <= dwr_data;
    end
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic [1:0]            cmd_r, cmd_nxt;
  logic [KW-1:0]         key_r, key_nxt;          // key, zero past its length
  logic [KW-1:0]         keysh_r, keysh_nxt;      // key bytes fed to the hash
  logic [3:0]            len_r, len_nxt;          // effective key length
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [5:0]            sidx_r, sidx_nxt;
  logic [63:0]           hash_r, hash_nxt;
  logic [3:0]            bcnt_r, bcnt_nxt;        // hashed byte count
  logic [5:0]            mcnt_r, mcnt_nxt;        // modulo bit count
  logic [RW-1:0]         rem_r, rem_nxt;          // remainder, then home slot
  logic [CW-1:0]         scan_addr_r, scan_addr_nxt;
  logic                  chk_vld_r, chk_vld_nxt;  // rd_q holds a scanned slot
  logic [AW-1:0]         chk_addr_r, chk_addr_nxt;
  logic [CW-1:0]         entry_cnt_r, entry_cnt_nxt;
  logic [5:0]            res_idx_r, res_idx_nxt;
  logic [31:0]           res_val_r, res_val_nxt;
  logic [1:0]            res_stat_r, res_stat_nxt;
  logic                  out_valid_r;
  logic [5:0]            out_idx_r;
  logic [31:0]           out_val_r;
  logic [1:0]            out_stat_r;

  // -------------------------------------------------------------------------
  // Key preparation at accept: saturate the length, cut at the first zero
  // byte, clear every byte past the effective length.
  // -------------------------------------------------------------------------
  logic [3:0]    in_lim;
  logic [3:0]    in_len_eff;
  logic [KW-1:0] in_key_msk;

  always_comb begin
    in_lim = (in_key_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : in_key_len;
    in_len_eff = in_lim;
    for (int i = MAX_KEY_BYTES - 1; i >= 0; i--) begin
      if (4'(i) < in_lim && in_key_bytes[8*i +: 8] == 8'd0) begin
        in_len_eff = 4'(i);
      end
    end
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      in_key_msk[8*i +: 8] = (4'(i) < in_len_eff) ? in_key_bytes[8*i +: 8] : 8'd0;
    end
  end

  // -------------------------------------------------------------------------
  // Probe decode of the slot read data
  // -------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] rd_value;
  logic [KW-1:0]         rd_key;
  logic [3:0]            rd_len;
  logic                  key_hit;
  logic                  probe_hit;    // empty slot for insert, equal key for locate
  logic                  is_insert;
  logic                  scan_issue;   // scan still has slots to read
  logic                  scan_found;
  logic                  scan_miss;
  logic                  sidx_ok;
  logic                  accept;
  logic                  out_free;
  logic [RW-1:0]         rem_sh;
  logic [RW-1:0]         rem_step;

  assign rd_value   = rd_data_q[VALUE_BITS-1:0];
  assign rd_key     = rd_data_q[VALUE_BITS +: KW];
  assign rd_len     = rd_data_q[VALUE_BITS+KW +: 4];
  assign key_hit    = rd_valid_q && rd_len == len_r && rd_key == key_r;
  assign is_insert  = cmd_r == CMD_INSERT;
  assign probe_hit  = is_insert ? !rd_valid_q : key_hit;
  assign scan_issue = scan_addr_r < CW'(CAPACITY);
  assign scan_found = chk_vld_r && probe_hit;
  assign scan_miss  = !chk_vld_r && !scan_issue;
  assign sidx_ok    = {26'd0, sidx_r} < 32'(CAPACITY);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  // One restoring step of the remainder: shift in the next hash bit, subtract
  // the capacity once when the partial value reaches it.
  assign rem_sh   = {rem_r[AW-1:0], hash_r[63]};
  assign rem_step = (rem_sh >= RW'(CAPACITY)) ? rem_sh - RW'(CAPACITY) : rem_sh;

  // -------------------------------------------------------------------------
  // Next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (scan_addr_r == CW'(CAPACITY - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_cmd)
            CMD_INSERT: begin
              state_nxt = (entry_cnt_r >= CW'(CAPACITY)) ? ST_DONE : ST_HASH;
            end
            CMD_LOCATE: state_nxt = ST_HASH;
            CMD_READ:   state_nxt = ST_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        if (bcnt_r == len_r) begin
          state_nxt = IS_POW2 ? ST_HOME : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mcnt_r == 6'd63) begin
          state_nxt = ST_HOME;
        end
      end
      ST_HOME:     state_nxt = ST_HOME_CHK;
      ST_HOME_CHK: state_nxt = probe_hit ? ST_DONE : ST_SCAN;
      ST_SCAN: begin
        if (scan_found || scan_miss) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD:     state_nxt = sidx_ok ? ST_RD_CHK : ST_DONE;
      ST_RD_CHK: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Datapath and memory control
  // -------------------------------------------------------------------------
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    keysh_nxt     = keysh_r;
    len_nxt       = len_r;
    val_nxt       = val_r;
    sidx_nxt      = sidx_r;
    hash_nxt      = hash_r;
    bcnt_nxt      = bcnt_r;
    mcnt_nxt      = mcnt_r;
    rem_nxt       = rem_r;
    scan_addr_nxt = scan_addr_r;
    chk_vld_nxt   = 1'b0;
    chk_addr_nxt  = chk_addr_r;
    entry_cnt_nxt = entry_cnt_r;
    res_idx_nxt   = res_idx_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    rd_addr       = rem_r[AW-1:0];
    wr_addr       = chk_addr_r;
    vwr_en        = 1'b0;
    vwr_data      = 1'b1;
    dwr_en        = 1'b0;
    dwr_data      = {len_r, key_r, val_r};

    unique case (state_r)
      ST_CLEAR: begin
        // sweep one valid bit per cycle
        wr_addr       = scan_addr_r[AW-1:0];
        vwr_en        = 1'b1;
        vwr_data      = 1'b0;
        scan_addr_nxt = scan_addr_r + CW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_cmd;
          key_nxt      = in_key_msk;
          keysh_nxt    = in_key_msk;
          len_nxt      = in_len_eff;
          val_nxt      = VALUE_BITS'(in_value_in);
          sidx_nxt     = in_slot_index;
          hash_nxt     = HASH_SEED;
          bcnt_nxt     = 4'd0;
          res_idx_nxt  = 6'd0;
          res_val_nxt  = 32'd0;
          res_stat_nxt = STAT_FULL;
        end
      end
      ST_HASH: begin
        if (bcnt_r == len_r) begin
          // hand the hash to the reducer, or take its low bits directly
          rem_nxt  = IS_POW2 ? RW'(hash_r[AW-1:0]) : '0;
          mcnt_nxt = 6'd0;
        end else begin
          hash_nxt  = (hash_r << HASH_SHIFT) + hash_r + 64'(keysh_r[7:0]);
          keysh_nxt = keysh_r >> 8;
          bcnt_nxt  = bcnt_r + 4'd1;
        end
      end
      ST_MOD: begin
        rem_nxt  = rem_step;
        hash_nxt = hash_r << 1;
        mcnt_nxt = mcnt_r + 6'd1;
      end
      ST_HOME: begin
        rd_addr = rem_r[AW-1:0];
      end
      ST_HOME_CHK: begin
        if (probe_hit) begin
          res_idx_nxt  = 6'(rem_r[AW-1:0]);
          res_stat_nxt = STAT_OK;
          if (is_insert) begin
            wr_addr       = rem_r[AW-1:0];
            vwr_en        = 1'b1;
            dwr_en        = 1'b1;
            entry_cnt_nxt = entry_cnt_r + CW'(1);
          end
        end else begin
          scan_addr_nxt = '0;
        end
      end
      ST_SCAN: begin
        // issue one slot per cycle, check the slot issued the cycle before
        rd_addr      = scan_addr_r[AW-1:0];
        chk_vld_nxt  = scan_issue;
        chk_addr_nxt = scan_addr_r[AW-1:0];
        if (scan_issue) begin
          scan_addr_nxt = scan_addr_r + CW'(1);
        end
        if (scan_found) begin
          res_idx_nxt  = 6'(chk_addr_r);
          res_stat_nxt = STAT_OK;
          if (is_insert) begin
            wr_addr       = chk_addr_r;
            vwr_en        = 1'b1;
            dwr_en        = 1'b1;
            entry_cnt_nxt = entry_cnt_r + CW'(1);
          end
        end else if (scan_miss) begin
          res_stat_nxt = is_insert ? STAT_FULL : STAT_NOT_FOUND;
        end
      end
      ST_RD: begin
        rd_addr = AW'(sidx_r);
        if (!sidx_ok) begin
          res_stat_nxt = STAT_EMPTY;
        end
      end
      ST_RD_CHK: begin
        if (rd_valid_q) begin
          res_idx_nxt  = sidx_r;
          res_val_nxt  = 32'(rd_value);
          res_stat_nxt = STAT_OK;
        end else begin
          res_stat_nxt = STAT_EMPTY;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      scan_addr_r <= '0;
      chk_vld_r   <= 1'b0;
      entry_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      entry_cnt_r <= entry_cnt_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    keysh_r    <= keysh_nxt;
    len_r      <= len_nxt;
    val_r      <= val_nxt;
    sidx_r     <= sidx_nxt;
    hash_r     <= hash_nxt;
    bcnt_r     <= bcnt_nxt;
    mcnt_r     <= mcnt_nxt;
    rem_r      <= rem_nxt;
    chk_addr_r <= chk_addr_nxt;
    res_idx_r  <= res_idx_nxt;
    res_val_r  <= res_val_nxt;
    res_stat_r <= res_stat_nxt;
    // load the output beat only when the slot is free; otherwise hold
    if (state_r == ST_DONE && out_free) begin
      out_idx_r  <= res_idx_r;
      out_val_r  <= res_val_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign in_stall      = state_r != ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_index_out = out_idx_r;
  assign out_value_out = out_val_r;
  assign out_status    = out_stat_r;

endmodule

// ===== src/skht_checker.sv =====
// ---------------------------------------------------------------------------
// String key hash table checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "string_key_hash_table_unit_defines.svh"

module skht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_index_out,
  input logic [31:0] out_value_out,
  input logic [1:0]  out_status
);
  import skht_pkg::*;

  // hold a stalled result beat
  `SKHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_index_out) && $stable(out_value_out), "stalled result beat changed")

  // a real command keeps the unit busy in the following cycle
  `SKHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall && in_cmd != CMD_UNDEF, in_stall, "command accepted but input not stalled")

  // a failed command reports slot zero and value zero
  `SKHT_ASSERT_SAME(a_fail_zero, out_valid && out_status != STAT_OK, out_index_out == 6'd0 && out_value_out == 32'd0, "failure result carries nonzero index or value")

endmodule

bind string_key_hash_table_unit skht_checker u_skht_checker (.*);
